// ----- sv/ffba_pkg.sv -----
// Shared constants, codes and types of the first-fit block allocator.
package ffba_pkg;

  // Default heap size in 8-byte granules.
  localparam int HEAP_GRANULES_DFLT = 4096;

  // Fixed field widths.
  localparam int REQ_W  = 24;               // request_bytes
  localparam int ADDR_W = 32;               // block_address, payload_address, heap_base
  localparam int STAT_W = 2;                // status
  localparam int NG_W   = REQ_W - 3 + 1;    // granules of a rounded-up request

  // Operation codes (request tuser).
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes (result tuser).
  localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] payload_address;
  } ffba_result_t;

endpackage

// ----- sv/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: control sequencer, header store, result register.
//
// Heap allocator over HEAP_GRANULES granules of 8 bytes starting at heap_base.
// Each block begins with a one-granule header {in_use, size} kept in a
// single-port-write, registered-read header memory that is never cleared; the
// first allocation on an empty heap lays down one free block covering the whole
// heap. An allocate request (tuser 0) rounds request_bytes up to granules,
// fails at once when the used count plus the request exceeds the heap, and
// otherwise walks the headers from granule 0, one header per clock, taking the
// first free block large enough; a remainder of two or more granules is split
// off as a new free block. A free request (tuser 1) clears the in-use bit of
// the block whose payload address is given; a misaligned or out-of-heap
// address changes nothing but still answers "freed". Blocks are never merged.
// A request is taken only when the engine is idle. An allocation visits headers
// in WALK, one memory read per header, then passes through MARK when a split is
// written, and ends in RESP; an immediate failure goes straight to RESP; a free
// passes through FREE_UPD to RESP (straight to RESP on a bad address).
// A finished result sits in the output register, so the next request is taken
// while the result waits. Write heap_base through cfg_wr_en/cfg_wr_data only
// while no request is in flight.
module first_fit_block_allocator #(
  parameter int HEAP_GRANULES = ffba_pkg::HEAP_GRANULES_DFLT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // configuration: heap_base
  input  logic                                       cfg_wr_en,
  input  logic [ffba_pkg::ADDR_W-1:0]                cfg_wr_data,
  // requests
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // [23:0] request_bytes, [55:24] block_address
  input  logic [ffba_pkg::REQ_W+ffba_pkg::ADDR_W-1:0] s_axis_tdata,
  // [0] opcode
  input  logic                                       s_axis_tuser,
  // results
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // [31:0] payload_address
  output logic [ffba_pkg::ADDR_W-1:0]                m_axis_tdata,
  // [1:0] status
  output logic [ffba_pkg::STAT_W-1:0]                m_axis_tuser
);
  import ffba_pkg::*;

  localparam int SW = $clog2(HEAP_GRANULES);       // granule index / size width
  localparam int UW = $clog2(HEAP_GRANULES + 1);   // used-count width
  localparam int HW = SW + 1;                      // header: {in_use, size}
  localparam int CW = (UW > NG_W ? UW : NG_W) + 1; // capacity compare width

  typedef enum logic [2:0] {
    IDLE,      // wait for a request
    WALK,      // examine one header per cycle
    MARK,      // write the in-use header after a split
    FREE_UPD,  // clear in-use bit, reduce used count
    RESP       // hand the result to the output register
  } state_t;

  state_t             state;
  logic [SW-1:0]      pos;        // header granule under examination
  logic [NG_W-1:0]    ngran;      // requested payload granules
  logic               init_hdr;   // header at pos is the fresh whole-heap block
  logic [UW-1:0]      used;       // granules in use, headers included
  logic [ADDR_W-1:0]  heap_base;
  ffba_result_t       res;

  // Header memory port
  logic               mem_we;
  logic [SW-1:0]      mem_waddr;
  logic [HW-1:0]      mem_wdata;
  logic               mem_re;
  logic [SW-1:0]      mem_raddr;
  logic [HW-1:0]      mem_rdata;

  logic               out_ready;

  // Request fields
  logic               in_op;
  logic [REQ_W-1:0]   in_req;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_fire;

  // Derived values
  logic [NG_W-1:0]    in_ngran;
  logic               no_room;
  logic [ADDR_W-1:0]  free_off;
  logic [ADDR_W-4:0]  free_gran;
  logic               free_ok;
  logic [SW-1:0]      free_idx;

  logic [HW-1:0]      hdr_cur;
  logic               hdr_busy;
  logic [SW-1:0]      hdr_size;
  logic               too_small;
  logic [SW:0]        next_pos;
  logic               walk_end;
  logic [SW-1:0]      ngran_s;
  logic [SW-1:0]      excess;
  logic               do_split;
  logic [SW:0]        split_pos;
  logic               split_in_heap;
  logic [ADDR_W-1:0]  alloc_addr;

  logic [SW:0]        free_dec;
  logic               free_to_zero;

  localparam logic [HW-1:0] INIT_HDR = {1'b0, SW'(HEAP_GRANULES - 1)};

  assign in_op   = s_axis_tuser;
  assign in_req  = s_axis_tdata[REQ_W-1:0];
  assign in_addr = s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];

  assign s_axis_tready = (state == IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // Round up to whole granules.
    in_ngran = NG_W'(({1'b0, in_req} + (REQ_W+1)'(7)) >> 3);
    no_room  = (CW'(used) + CW'(in_ngran)) > CW'(HEAP_GRANULES);

    // Free address decode relative to heap_base.
    free_off  = in_addr - heap_base;
    free_gran = free_off[ADDR_W-1:3];
    free_ok   = (free_off[2:0] == 3'b000) && (free_gran != '0) &&
                (free_gran <= (ADDR_W-3)'(HEAP_GRANULES));
    free_idx  = SW'(free_gran - (ADDR_W-3)'(1));

    // Header walk.
    hdr_cur   = init_hdr ? INIT_HDR : mem_rdata;
    hdr_busy  = hdr_cur[SW];
    hdr_size  = hdr_cur[SW-1:0];
    too_small = ngran > NG_W'(hdr_size);
    next_pos  = (SW+1)'(pos) + (SW+1)'(1) + (SW+1)'(hdr_size);
    walk_end  = next_pos > (SW+1)'(HEAP_GRANULES - 2);
    ngran_s   = SW'(ngran);
    excess    = hdr_size - ngran_s;
    do_split  = excess >= SW'(2);
    split_pos = (SW+1)'(pos) + (SW+1)'(1) + (SW+1)'(ngran_s);
    split_in_heap = split_pos < (SW+1)'(HEAP_GRANULES);
    alloc_addr = heap_base + ADDR_W'({(SW+1)'(pos) + (SW+1)'(1), 3'b000});

    // Free bookkeeping.
    free_dec     = (SW+1)'(hdr_size) + (SW+1)'(1);
    free_to_zero = (UW+1)'(free_dec) >= (UW+1)'(used);
  end

  // Header memory access per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = pos;
    unique case (state)
      IDLE: begin
        if (in_fire && in_op == OP_ALLOC && !no_room) begin
          // Empty heap: lay down one free block over the whole heap.
          mem_we    = (used == '0);
          mem_waddr = '0;
          mem_wdata = INIT_HDR;
          mem_re    = 1'b1;
          mem_raddr = '0;
        end else if (in_fire && in_op == OP_FREE && free_ok) begin
          mem_re    = 1'b1;
          mem_raddr = free_idx;
        end
      end
      WALK: begin
        if (hdr_busy || too_small) begin
          // Fetch the next header.
          mem_re    = !walk_end;
          mem_raddr = SW'(next_pos);
        end else if (do_split) begin
          // Write the free remainder; the in-use header follows in MARK.
          mem_we    = split_in_heap;
          mem_waddr = SW'(split_pos);
          mem_wdata = {1'b0, excess - SW'(1)};
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, hdr_size};
        end
      end
      MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, ngran_s};
      end
      FREE_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, hdr_size};
      end
      RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      used      <= '0;
      heap_base <= '0;
      init_hdr  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_base <= cfg_wr_data;
      end
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            ngran <= in_ngran;
            if (in_op == OP_ALLOC) begin
              pos      <= '0;
              // Only a walk that laid down the whole-heap block uses it.
              init_hdr <= (used == '0) && !no_room;
              if (no_room) begin
                res   <= '{status: ST_NO_SPACE, payload_address: '0};
                state <= RESP;
              end else begin
                state <= WALK;
              end
            end else begin
              pos <= free_idx;
              res <= '{status: ST_FREED, payload_address: '0};
              // Bad address: answer freed and change nothing.
              state <= free_ok ? FREE_UPD : RESP;
            end
          end
        end
        WALK: begin
          init_hdr <= 1'b0;
          if (hdr_busy || too_small) begin
            if (walk_end) begin
              res   <= '{status: ST_NO_SPACE, payload_address: '0};
              state <= RESP;
            end else begin
              pos <= SW'(next_pos);
            end
          end else begin
            res <= '{status: ST_ALLOCATED, payload_address: alloc_addr};
            if (do_split) begin
              state <= MARK;
            end else begin
              used  <= UW'(used + UW'(hdr_size) + UW'(1));
              state <= RESP;
            end
          end
        end
        MARK: begin
          used  <= UW'(used + UW'(ngran_s) + UW'(1));
          state <= RESP;
        end
        FREE_UPD: begin
          // Saturate at zero on a repeated or stray free.
          used  <= free_to_zero ? '0 : UW'(used - UW'(free_dec));
          state <= RESP;
        end
        RESP: begin
          if (out_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  ffba_hdr_mem #(
    .DEPTH (HEAP_GRANULES),
    .WIDTH (HW)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffba_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (state == RESP),
    .load_data     (res),
    .load_ready    (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- sv/ffba_hdr_mem.sv -----
// Header memory: one write port, one read port, registered read data.
module ffba_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ffba_out_reg.sv -----
// Result output register: holds one result until the downstream side takes it.
module ffba_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  ffba_pkg::ffba_result_t    load_data,
  output logic                      load_ready,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [ffba_pkg::ADDR_W-1:0] m_axis_tdata,
  output logic [ffba_pkg::STAT_W-1:0] m_axis_tuser
);
  import ffba_pkg::*;

  ffba_result_t held;

  assign load_ready    = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = held.payload_address;
  assign m_axis_tuser  = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load && load_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held <= load_data;
    end
  end

endmodule

// ----- sv/ffba_chk.sv -----
// Port-level assertions for the first-fit block allocator, bound to its top level.
module ffba_chk (
  input logic                                       clk,
  input logic                                       rst,
  input logic                                       cfg_wr_en,
  input logic [ffba_pkg::ADDR_W-1:0]                cfg_wr_data,
  input logic                                       s_axis_tvalid,
  input logic                                       s_axis_tready,
  input logic [ffba_pkg::REQ_W+ffba_pkg::ADDR_W-1:0] s_axis_tdata,
  input logic                                       s_axis_tuser,
  input logic                                       m_axis_tvalid,
  input logic                                       m_axis_tready,
  input logic [ffba_pkg::ADDR_W-1:0]                m_axis_tdata,
  input logic [ffba_pkg::STAT_W-1:0]                m_axis_tuser
);
  import ffba_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only a successful allocation carries an address.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_ALLOCATED |-> m_axis_tdata == '0)
    else $error("nonzero address on failed allocate or free");

  // One request at a time: the engine is busy right after taking one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in flight");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (.*);
